/* rtl/dsh_pkg.sv */
// Package for the diamond-square heightmap core: payload structs, sizes and constants.
// Used by dsh_settle, the top level and the testbench; depends on nothing.
package dsh_pkg;
	localparam int GRID_LEVEL_DEF = 7;
	localparam logic [31:0] LFSR_TAPS = 32'h8020_0003;
	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_NOT_READY = 2'd1;
	localparam logic [1:0] ST_OUTSIDE = 2'd2;
	localparam logic OP_GENERATE = 1'b0;
	localparam logic [1:0] REG_MAX_HEIGHT = 2'd0;
	localparam logic [1:0] REG_RNG_SEED = 2'd1;
	localparam logic [1:0] REG_LEVEL = 2'd2;
	localparam logic [1:0] Q_TL = 2'd0;
	localparam logic [1:0] Q_TR = 2'd1;
	localparam logic [1:0] Q_BR = 2'd2;
	localparam logic [1:0] Q_BL = 2'd3;

	typedef struct packed {
		logic       op;
		logic [7:0] row;
		logic [7:0] col;
	} in_word_t;

	typedef struct packed {
		logic [15:0] height;
		logic [1:0]  status;
	} out_word_t;

	typedef struct packed {
		logic [1:0]  index;
		logic [31:0] data;
	} cfg_word_t;

	function automatic logic [31:0] lfsr_next(input logic [31:0] v);
		lfsr_next = v[0] ? ((v >> 1) ^ LFSR_TAPS) : (v >> 1);
	endfunction
endpackage

/* rtl/dsh_ram.sv */
// Generic single-port RAM with registered read.
// Standalone; no package needed.
module dsh_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

/* rtl/dsh_settle.sv */
// Shared arithmetic unit: noise draw, average and clamp; it takes no new start until the current result is done.
// Depends on dsh_pkg.
module dsh_settle (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        uniform,
	input  logic [17:0] sum,
	input  logic        four,
	input  logic [2:0]  depth,
	input  logic [15:0] max_height,
	input  logic [31:0] rnd,
	output logic        done,
	output logic [15:0] result
);
	import dsh_pkg::*;

	logic [1:0]  ph_q;
	logic [63:0] prod_q;
	logic [16:0] avg_q;
	logic        uni_q;
	logic [17:0] quot;
	logic [16:0] span;
	logic signed [18:0] s;
	logic signed [18:0] ns;
	logic signed [19:0] val;

	// Divide by three as a reciprocal multiply: (x*174763)>>19 is exact below 2^19.
	logic [35:0] q3;
	assign q3 = {18'd0, sum} * 36'd174763;
	assign quot = four ? (sum >> 2) : {1'b0, q3[35:19]};
	assign span = uniform ? ({1'b0, max_height} + 17'd1) : ({max_height, 1'b1});
	assign s = uni_q ? 19'sd0
		: $signed({2'b00, prod_q[48:32]}) - $signed({3'b000, max_height});
	assign ns = s >>> depth;
	assign val = uni_q ? $signed({3'b000, prod_q[48:32]})
		: $signed({3'b000, avg_q}) + ns;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= 2'd0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			unique case (ph_q)
				2'd0: if (start) begin
					prod_q <= {32'd0, rnd} * {47'd0, span};
					avg_q <= quot[16:0];
					uni_q <= uniform;
					ph_q <= 2'd1;
				end
				2'd1: begin
					if (val < 0) result <= 16'd0;
					else if (val > $signed({4'd0, max_height})) result <= max_height;
					else result <= val[15:0];
					done <= 1'b1;
					ph_q <= 2'd0;
				end
				default: ph_q <= 2'd0;
			endcase
		end
	end

	a_done_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(ph_q) == 2'd1) else $error("settle done out of order");
	a_no_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ph_q == 2'd1 |=> ph_q == 2'd0) else $error("settle phase stuck");
	a_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> result <= max_height) else $error("settle clamp failed");
endmodule

/* rtl/diamond_square_heightmap_core.sv */
// Top level of the diamond-square heightmap core: sequencer, stores, handshakes.
// Depends on dsh_pkg, dsh_ram and dsh_settle.
//
//  channel | dir | handshake            | word
//  in      | in  | in_valid/in_ready    | op, row, col
//  out     | out | out_valid/out_ready  | height, status
//  cfg     | in  | cfg_valid/cfg_ready  | index, data
//
// A read result passes through the registered height RAM port, then the result
// register, then the S_RESP state that raises out_valid.
// A generate first clears the valid RAM, one entry a cycle (side*side entries of the
// largest grid, 16641 at level 7), then runs every settle through the one shared
// settle unit and the single-port height and valid RAMs.
// Reset clears control and configuration registers only; the height RAM holds garbage until generate.
// in_ready is low while an item is in work or its result is still waiting;
// cfg_ready is low while an item is in work.
module diamond_square_heightmap_core #(
	parameter int GRID_LEVEL = dsh_pkg::GRID_LEVEL_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  dsh_pkg::in_word_t in_word,
	output logic              out_valid,
	input  logic              out_ready,
	output dsh_pkg::out_word_t out_word,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  dsh_pkg::cfg_word_t cfg_word
);
	import dsh_pkg::*;

	localparam int SIDE = (1 << GRID_LEVEL) + 1;
	localparam int N = SIDE * SIDE;
	localparam int AW = $clog2(N);
	localparam int CW = GRID_LEVEL + 1;
	localparam int DW = $clog2(GRID_LEVEL + 1);

	typedef enum logic [4:0] {
		S_IDLE, S_RD_DONE, S_CLEAR, S_CORNER, S_CORNER_W,
		S_REF_INIT, S_LD, S_LD_W, S_MID, S_MID_W, S_E_CHK, S_E_CHK_W, S_E_NB,
		S_E_NB_W, S_E_SET, S_E_SET_W, S_NEXT, S_POP, S_RESP
	} state_t;

	state_t state_q;
	logic [15:0] max_height_q;
	logic [31:0] seed_q;
	logic [2:0]  level_q;
	logic        map_ready_q;
	logic [31:0] lfsr_q;
	logic [1:0]  qs_q [GRID_LEVEL+1];
	logic [3:0]  d_q;
	logic [3:0]  lv_q;
	logic [AW-1:0] clr_q;
	logic [1:0]  k_q;
	logic [CW-1:0] x_q, y_q, n_q;
	logic [15:0] c_q [4];
	logic [15:0] mid_q, nb_q;
	logic        nbv_q;
	logic [1:0]  e_q;
	logic        out_valid_q;
	out_word_t   out_q;

	logic          h_we, v_we;
	logic [AW-1:0] h_addr, v_addr;
	logic [15:0]   h_wdata, h_rdata;
	logic          v_wdata, v_rdata;

	logic        st_start, st_uniform, st_four, st_done;
	logic [17:0] st_sum;
	logic [15:0] st_res;
	logic [31:0] lfsr_nx;

	assign lfsr_nx = lfsr_next(lfsr_q);

	dsh_ram #(.WIDTH(16), .DEPTH(N)) u_height (
		.clk(clk), .we(h_we), .addr(h_addr), .wdata(h_wdata), .rdata(h_rdata));
	dsh_ram #(.WIDTH(1), .DEPTH(N)) u_valid (
		.clk(clk), .we(v_we), .addr(v_addr), .wdata(v_wdata), .rdata(v_rdata));

	dsh_settle u_settle (
		.clk(clk), .arst_n(arst_n), .start(st_start), .uniform(st_uniform),
		.sum(st_sum), .four(st_four), .depth(d_q[2:0]), .max_height(max_height_q),
		.rnd(lfsr_nx), .done(st_done), .result(st_res));

	function automatic logic [AW-1:0] at(input logic [CW-1:0] r, input logic [CW-1:0] c);
		logic [AW+CW-1:0] p;
		p = (AW+CW)'(r) * (AW+CW)'(SIDE) + (AW+CW)'(c);
		return p[AW-1:0];
	endfunction

	logic [CW-1:0] h_n, s1, side_w;
	assign h_n = n_q >> 1;
	assign s1 = CW'(1) << lv_q;
	assign side_w = s1 + CW'(1);

	// Edge point and its outer neighbour for edge e (left, top, right, bottom).
	logic [CW-1:0] er, ec, nr, nc;
	logic [CW:0]   far;
	logic          nb_ok;
	logic [15:0]   ea, eb;
	always_comb begin
		er = y_q + h_n; ec = x_q; nr = er; nc = x_q - h_n; far = '0;
		ea = c_q[0]; eb = c_q[3]; nb_ok = (x_q >= h_n);
		unique case (e_q)
			2'd0: begin end
			2'd1: begin
				er = y_q; ec = x_q + h_n; nr = y_q - h_n; nc = ec;
				eb = c_q[1]; nb_ok = (y_q >= h_n);
			end
			2'd2: begin
				er = y_q + h_n; ec = x_q + n_q; nr = er;
				far = {1'b0, x_q} + {1'b0, n_q} + {1'b0, h_n};
				nc = far[CW-1:0]; ea = c_q[1]; eb = c_q[2];
				nb_ok = far < {1'b0, side_w};
			end
			default: begin
				er = y_q + n_q; ec = x_q + h_n;
				far = {1'b0, y_q} + {1'b0, n_q} + {1'b0, h_n};
				nr = far[CW-1:0]; nc = ec; ea = c_q[3]; eb = c_q[2];
				nb_ok = far < {1'b0, side_w};
			end
		endcase
	end

	// Corner k position for loading and for the initial draw.
	logic [CW-1:0] kr, kc;
	always_comb begin
		unique case (k_q)
			Q_TL: begin kr = y_q; kc = x_q; end
			Q_TR: begin kr = y_q; kc = x_q + n_q; end
			Q_BR: begin kr = y_q + n_q; kc = x_q + n_q; end
			default: begin kr = y_q + n_q; kc = x_q; end
		endcase
	end

	// Origin of the sub-square at depth d from the quadrant stack.
	logic [CW-1:0] ox, oy;
	logic [CW-1:0] cstep;
	always_comb begin
		ox = '0; oy = '0;
		for (int k = 1; k <= GRID_LEVEL; k++) begin
			cstep = CW'(1) << (lv_q - 4'(k));
			if (4'(k) <= d_q) begin
				if (qs_q[k] == Q_TR || qs_q[k] == Q_BR) ox = ox + cstep;
				if (qs_q[k] == Q_BR || qs_q[k] == Q_BL) oy = oy + cstep;
			end
		end
	end

	always_comb begin
		h_we = 1'b0; h_wdata = st_res; h_addr = at(kr, kc);
		v_we = 1'b0; v_wdata = 1'b1; v_addr = at(er, ec);
		st_start = 1'b0; st_uniform = 1'b0; st_four = 1'b0; st_sum = '0;
		unique case (state_q)
			S_IDLE: h_addr = at(CW'(in_word.row), CW'(in_word.col));
			S_CLEAR: begin v_we = 1'b1; v_wdata = 1'b0; v_addr = clr_q; end
			S_CORNER: begin st_start = 1'b1; st_uniform = 1'b1; end
			S_CORNER_W: if (st_done) begin
				h_we = 1'b1; v_we = 1'b1; v_addr = at(kr, kc);
			end
			S_MID: begin
				st_start = 1'b1; st_four = 1'b1;
				st_sum = 18'(c_q[0]) + 18'(c_q[1]) + 18'(c_q[2]) + 18'(c_q[3]);
			end
			S_MID_W: begin
				h_addr = at(y_q + h_n, x_q + h_n);
				v_addr = h_addr;
				if (st_done) begin h_we = 1'b1; v_we = 1'b1; end
			end
			S_E_CHK: v_addr = at(er, ec);
			S_E_NB: begin h_addr = at(nr, nc); v_addr = h_addr; end
			S_E_SET: begin
				st_start = 1'b1; st_four = nbv_q;
				st_sum = 18'(ea) + 18'(eb) + 18'(mid_q) + (nbv_q ? 18'(nb_q) : 18'd0);
			end
			S_E_SET_W: begin
				h_addr = at(er, ec); v_addr = h_addr;
				if (st_done) begin h_we = 1'b1; v_we = 1'b1; end
			end
			default: begin end
		endcase
	end

	assign in_ready = (state_q == S_IDLE) && !out_valid_q;
	assign cfg_ready = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_word = out_q;

	logic [3:0] lvl_eff;
	always_comb begin
		lvl_eff = {1'b0, level_q};
		if (lvl_eff < 4'd1) lvl_eff = 4'd1;
		if (lvl_eff > 4'(GRID_LEVEL)) lvl_eff = 4'(GRID_LEVEL);
	end

	// Grid side of the level in force, for the range check of a read.
	logic [CW:0] rd_side;
	assign rd_side = ((CW+1)'(1) << lvl_eff) + (CW+1)'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			max_height_q <= 16'hFFFF;
			seed_q <= 32'd1;
			level_q <= 3'd7;
			map_ready_q <= 1'b0;
			lfsr_q <= 32'd1;
			out_valid_q <= 1'b0;
			d_q <= '0;
			for (int i = 0; i <= GRID_LEVEL; i++) qs_q[i] <= Q_TL;
		end else begin
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_word.index)
					REG_MAX_HEIGHT: max_height_q <= cfg_word.data[15:0];
					REG_RNG_SEED: seed_q <= cfg_word.data;
					REG_LEVEL: begin level_q <= cfg_word.data[2:0]; map_ready_q <= 1'b0; end
					default: begin end
				endcase
			end
			unique case (state_q)
				S_IDLE: if (in_valid && in_ready) begin
					lv_q <= lvl_eff;
					if (in_word.op == OP_GENERATE) begin
						clr_q <= '0;
						lfsr_q <= (seed_q == 32'd0) ? 32'd1 : seed_q;
						state_q <= S_CLEAR;
					end else begin
						// The RAM latches the read address at this edge.
						state_q <= S_RD_DONE;
						out_q.height <= 16'd0;
						if (!map_ready_q) begin
							out_q.status <= ST_NOT_READY; state_q <= S_RESP;
						end else if ({1'b0, in_word.row} >= 9'(rd_side)
							|| {1'b0, in_word.col} >= 9'(rd_side)) begin
							out_q.status <= ST_OUTSIDE; state_q <= S_RESP;
						end
					end
				end
				S_RD_DONE: begin
					out_q.height <= h_rdata; out_q.status <= ST_OK; state_q <= S_RESP;
				end
				S_CLEAR: begin
					if (clr_q == AW'(N - 1)) begin
						x_q <= '0; y_q <= '0; n_q <= s1; k_q <= Q_TL; d_q <= '0;
						for (int i = 0; i <= GRID_LEVEL; i++) qs_q[i] <= Q_TL;
						state_q <= S_CORNER;
					end
					clr_q <= clr_q + AW'(1);
				end
				S_CORNER: begin lfsr_q <= lfsr_nx; state_q <= S_CORNER_W; end
				S_CORNER_W: if (st_done) begin
					k_q <= k_q + 2'd1;
					state_q <= (k_q == Q_BL) ? S_REF_INIT : S_CORNER;
				end
				S_REF_INIT: begin
					x_q <= ox; y_q <= oy; n_q <= s1 >> d_q; k_q <= Q_TL; state_q <= S_LD;
				end
				S_LD: state_q <= S_LD_W;
				S_LD_W: begin
					c_q[k_q] <= h_rdata; k_q <= k_q + 2'd1;
					state_q <= (k_q == Q_BL) ? S_MID : S_LD;
				end
				S_MID: begin lfsr_q <= lfsr_nx; state_q <= S_MID_W; end
				S_MID_W: if (st_done) begin
					mid_q <= st_res; e_q <= 2'd0; state_q <= S_E_CHK;
				end
				S_E_CHK: state_q <= S_E_CHK_W;
				S_E_CHK_W: begin
					if (v_rdata) state_q <= S_NEXT;
					else if (nb_ok) state_q <= S_E_NB;
					else begin nbv_q <= 1'b0; state_q <= S_E_SET; end
				end
				S_E_NB: state_q <= S_E_NB_W;
				S_E_NB_W: begin nb_q <= h_rdata; nbv_q <= v_rdata; state_q <= S_E_SET; end
				S_E_SET: begin lfsr_q <= lfsr_nx; state_q <= S_E_SET_W; end
				S_E_SET_W: if (st_done) state_q <= S_NEXT;
				S_NEXT: begin
					if (e_q != 2'd3) begin
						e_q <= e_q + 2'd1; state_q <= S_E_CHK;
					end else if (d_q + 4'd1 < lv_q) begin
						d_q <= d_q + 4'd1; qs_q[DW'(d_q + 4'd1)] <= Q_TL;
						state_q <= S_REF_INIT;
					end else begin
						state_q <= S_POP;
					end
				end
				// Climb past finished quadrants, then step to the next sibling; at depth zero the map is done.
				S_POP: begin
					if (d_q == 4'd0) begin
						map_ready_q <= 1'b1; out_q <= '0; state_q <= S_RESP;
					end else if (qs_q[DW'(d_q)] == Q_BL) begin
						d_q <= d_q - 4'd1;
					end else begin
						qs_q[DW'(d_q)] <= qs_q[DW'(d_q)] + 2'd1; state_q <= S_REF_INIT;
					end
				end
				S_RESP: begin out_valid_q <= 1'b1; state_q <= S_IDLE; end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |-> !out_valid_q) else $error("accepted with result pending");
	a_resp_valid: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_RESP |=> out_valid_q) else $error("result word lost");
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> out_q.status != 2'd3) else $error("bad status code");
	a_height_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.status != ST_OK |-> out_q.height == 16'd0)
		else $error("nonzero height with error status");
endmodule

/* dv/diamond_square_heightmap_core_tb.sv */
// Testbench for diamond_square_heightmap_core: directed and random generate/read traffic.
// Depends on dsh_pkg and the core RTL; it checks each result against its own terrain predictor.
module diamond_square_heightmap_core_tb;
	import dsh_pkg::*;

	localparam logic OP_READ = ~OP_GENERATE;
	localparam int SIDE_MAX = (1 << GRID_LEVEL_DEF) + 1;
	localparam int POINTS = SIDE_MAX * SIDE_MAX;
	localparam int IDLE_LIMIT = 1500000;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	in_word_t in_word;
	logic out_valid;
	logic out_ready;
	out_word_t out_word;
	logic cfg_valid;
	logic cfg_ready;
	cfg_word_t cfg_word;

	diamond_square_heightmap_core u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_word(in_word),
		.out_valid(out_valid), .out_ready(out_ready), .out_word(out_word),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_word(cfg_word)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Terrain predictor state.
	logic [15:0] terrain[POINTS];
	bit point_set[POINTS];
	bit [1:0] quad_path[GRID_LEVEL_DEF + 1];
	logic [31:0] noise_state;
	bit map_built;
	logic [15:0] cur_max;
	logic [31:0] cur_seed;
	logic [2:0] cur_level;

	out_word_t pending_words[$];
	int errors;
	bit fast_sender;
	bit stall_request;
	int idle_cycles;

	function automatic int eff_level();
		if (cur_level < 1)
			return 1;
		if (cur_level > GRID_LEVEL_DEF)
			return GRID_LEVEL_DEF;
		return int'(cur_level);
	endfunction

	function automatic logic [31:0] noise_advance();
		noise_state = noise_state[0] ? ((noise_state >> 1) ^ LFSR_TAPS) : (noise_state >> 1);
		return noise_state;
	endfunction

	function automatic int draw_flat();
		longint unsigned p;
		p = longint'(noise_advance()) * (longint'(cur_max) + 1);
		return int'(p >> 32);
	endfunction

	function automatic int draw_jitter(int depth);
		longint unsigned p;
		int s;
		p = longint'(noise_advance()) * (2 * longint'(cur_max) + 1);
		s = int'(p >> 32) - int'(cur_max);
		return s >>> depth;
	endfunction

	function automatic int spot(int r, int c);
		return r * SIDE_MAX + c;
	endfunction

	function automatic void place(int idx, int sum, int cnt, int depth);
		int v;
		v = sum / cnt + draw_jitter(depth);
		if (v < 0)
			v = 0;
		if (v > int'(cur_max))
			v = int'(cur_max);
		terrain[idx] = 16'(v);
		point_set[idx] = 1'b1;
	endfunction

	// One diamond step and the four square steps of a sub-square.
	function automatic void refine_square(int x, int y, int n, int depth, int side);
		int h, tl, tr, br, bl, m, i, j;
		h = n / 2;
		tl = int'(terrain[spot(y, x)]);
		tr = int'(terrain[spot(y, x + n)]);
		br = int'(terrain[spot(y + n, x + n)]);
		bl = int'(terrain[spot(y + n, x)]);
		place(spot(y + h, x + h), tl + tr + br + bl, 4, depth);
		m = int'(terrain[spot(y + h, x + h)]);
		i = spot(y + h, x);
		if (!point_set[i]) begin
			j = (x >= h) ? spot(y + h, x - h) : 0;
			if (x >= h && point_set[j])
				place(i, tl + bl + m + int'(terrain[j]), 4, depth);
			else
				place(i, tl + bl + m, 3, depth);
		end
		i = spot(y, x + h);
		if (!point_set[i]) begin
			j = (y >= h) ? spot(y - h, x + h) : 0;
			if (y >= h && point_set[j])
				place(i, tl + tr + m + int'(terrain[j]), 4, depth);
			else
				place(i, tl + tr + m, 3, depth);
		end
		// The right and bottom neighbors are tested against the grid side of the level in force.
		i = spot(y + h, x + n);
		if (!point_set[i]) begin
			j = (x + n + h < side) ? spot(y + h, x + n + h) : 0;
			if (x + n + h < side && point_set[j])
				place(i, tr + br + m + int'(terrain[j]), 4, depth);
			else
				place(i, tr + br + m, 3, depth);
		end
		i = spot(y + n, x + h);
		if (!point_set[i]) begin
			j = (y + n + h < side) ? spot(y + n + h, x + h) : 0;
			if (y + n + h < side && point_set[j])
				place(i, bl + br + m + int'(terrain[j]), 4, depth);
			else
				place(i, bl + br + m, 3, depth);
		end
	endfunction

	function automatic void refine_path(int d, int lv, int side);
		int x, y, c;
		x = 0;
		y = 0;
		for (int k = 1; k <= d; k++) begin
			c = 1 << (lv - k);
			if (quad_path[k] == Q_TR || quad_path[k] == Q_BR)
				x += c;
			if (quad_path[k] == Q_BR || quad_path[k] == Q_BL)
				y += c;
		end
		refine_square(x, y, 1 << (lv - d), d, side);
	endfunction

	function automatic void build_terrain();
		int lv, s1, side, d;
		lv = eff_level();
		s1 = 1 << lv;
		side = s1 + 1;
		d = 0;
		foreach (point_set[i])
			point_set[i] = 1'b0;
		foreach (quad_path[i])
			quad_path[i] = Q_TL;
		noise_state = (cur_seed != 0) ? cur_seed : 32'd1;
		terrain[spot(0, 0)] = 16'(draw_flat());
		terrain[spot(0, s1)] = 16'(draw_flat());
		terrain[spot(s1, s1)] = 16'(draw_flat());
		terrain[spot(s1, 0)] = 16'(draw_flat());
		point_set[spot(0, 0)] = 1'b1;
		point_set[spot(0, s1)] = 1'b1;
		point_set[spot(s1, s1)] = 1'b1;
		point_set[spot(s1, 0)] = 1'b1;
		refine_path(0, lv, side);
		forever begin
			if (d + 1 < lv) begin
				d++;
				quad_path[d] = Q_TL;
			end else begin
				while (d > 0 && quad_path[d] == Q_BL)
					d--;
				if (d == 0)
					break;
				quad_path[d]++;
			end
			refine_path(d, lv, side);
		end
		map_built = 1'b1;
	endfunction

	function automatic out_word_t predict_word(in_word_t w);
		out_word_t r;
		int side;
		side = (1 << eff_level()) + 1;
		r = '0;
		r.status = ST_OK;
		if (w.op == OP_GENERATE)
			build_terrain();
		else if (!map_built)
			r.status = ST_NOT_READY;
		else if (w.row >= side || w.col >= side)
			r.status = ST_OUTSIDE;
		else
			r.height = terrain[spot(w.row, w.col)];
		return r;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (fast_sender || r < 50)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Entered and left at a falling edge; valid stays high when no gap follows.
	task automatic send_word(logic op, logic [7:0] row, logic [7:0] col);
		int gap;
		in_word_t w;
		w.op = op;
		w.row = row;
		w.col = col;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_word <= w;
		do
			@(posedge clk);
		while (!in_ready);
		pending_words = {pending_words, predict_word(w)};
		@(negedge clk);
	endtask

	task automatic read_any();
		int side;
		side = (1 << eff_level()) + 1;
		if ($urandom_range(0, 9) < 8)
			send_word(OP_READ, 8'($urandom_range(0, side - 1)),
				8'($urandom_range(0, side - 1)));
		else
			send_word(OP_READ, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
	endtask

	// Register writes only once the block has drained.
	task automatic settle_idle();
		in_valid <= 1'b0;
		while (pending_words.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_word <= '{index: idx, data: data};
		do
			@(posedge clk);
		while (!cfg_ready);
		case (idx)
			REG_MAX_HEIGHT: cur_max = data[15:0];
			REG_RNG_SEED: cur_seed = data;
			REG_LEVEL: begin
				cur_level = data[2:0];
				map_built = 1'b0;
			end
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic setup_map(logic [15:0] mh, logic [31:0] seed, logic [2:0] lv);
		settle_idle();
		write_reg(REG_MAX_HEIGHT, {16'd0, mh});
		write_reg(REG_RNG_SEED, seed);
		write_reg(REG_LEVEL, {29'd0, lv});
	endtask

	task automatic test_before_generate();
		send_word(OP_READ, 8'd0, 8'd0);
		send_word(OP_READ, 8'd255, 8'd255);
		send_word(OP_READ, 8'd3, 8'd200);
	endtask

	task automatic test_small_grids();
		setup_map(16'hFFFF, 32'd1, 3'd1);
		send_word(OP_GENERATE, 8'hFF, 8'hFF);
		for (int r = 0; r < 3; r++)
			for (int c = 0; c < 3; c++)
				send_word(OP_READ, 8'(r), 8'(c));
		send_word(OP_READ, 8'd3, 8'd0);
		// A zero level acts as one, a zero seed as one, a zero height flattens all.
		setup_map(16'd0, 32'd0, 3'd0);
		send_word(OP_GENERATE, 8'd0, 8'd0);
		send_word(OP_READ, 8'd1, 8'd1);
		send_word(OP_READ, 8'd2, 8'd2);
		setup_map(16'd1, 32'hFFFF_FFFF, 3'd2);
		send_word(OP_GENERATE, 8'd0, 8'd0);
		send_word(OP_READ, 8'd2, 8'd3);
		send_word(OP_READ, 8'd4, 8'd4);
	endtask

	task automatic test_full_grid();
		setup_map(16'hFFFF, 32'hA5C3_0F69, 3'd7);
		send_word(OP_GENERATE, 8'd0, 8'd0);
		send_word(OP_READ, 8'd0, 8'd128);
		send_word(OP_READ, 8'd128, 8'd128);
		send_word(OP_READ, 8'd128, 8'd0);
		send_word(OP_READ, 8'd64, 8'd64);
		send_word(OP_READ, 8'd129, 8'd0);
		send_word(OP_READ, 8'd0, 8'd255);
	endtask

	task automatic test_level_change();
		settle_idle();
		write_reg(REG_LEVEL, 32'd7);
		send_word(OP_READ, 8'd5, 8'd5);
	endtask

	task automatic test_output_stall();
		setup_map(16'd1000, 32'h1234_5678, 3'd3);
		send_word(OP_GENERATE, 8'd0, 8'd0);
		settle_idle();
		fast_sender = 1'b1;
		stall_request = 1'b1;
		repeat (12) read_any();
		fast_sender = 1'b0;
	endtask

	task automatic test_random();
		int lv, mh;
		for (int ph = 0; ph < 20; ph++) begin
			lv = ($urandom_range(0, 9) == 0) ? 6 : $urandom_range(1, 5);
			case ($urandom_range(0, 4))
				0: mh = 0;
				1: mh = 65535;
				2: mh = $urandom_range(1, 15);
				default: mh = $urandom_range(1, 65535);
			endcase
			setup_map(16'(mh), ($urandom_range(0, 9) == 0) ? 32'd0 : $urandom, 3'(lv));
			send_word(OP_GENERATE, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
			fast_sender = (ph % 4 == 1);
			for (int k = 0; k < 40; k++) begin
				if ($urandom_range(0, 99) == 0)
					send_word(OP_GENERATE, 8'($urandom_range(0, 255)),
						8'($urandom_range(0, 255)));
				else
					read_any();
			end
			fast_sender = 1'b0;
		end
	endtask

	// Receiver: mostly ready, short stalls, and one long hold on request.
	initial begin
		int hold;
		hold = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_request) begin
				stall_request = 1'b0;
				hold = 400;
			end
			if (hold > 0) begin
				hold--;
				out_ready <= 1'b0;
			end else if ($urandom_range(0, 99) < 75) begin
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b0;
				if ($urandom_range(0, 9) == 0)
					hold = $urandom_range(10, 60);
			end
		end
	end

	always @(posedge clk) begin
		out_word_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_words.size() == 0) begin
				$error("unexpected word: height %0d status %0d", out_word.height,
					out_word.status);
				errors++;
			end else begin
				want = pending_words.pop_front();
				if (out_word.height !== want.height) begin
					$error("height: expected %0d, got %0d", want.height, out_word.height);
					errors++;
				end
				if (out_word.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, out_word.status);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("diamond_square_heightmap_core verification failed");
			$finish;
		end
	end

	initial begin
		errors = 0;
		idle_cycles = 0;
		fast_sender = 1'b0;
		stall_request = 1'b0;
		map_built = 1'b0;
		cur_max = 16'hFFFF;
		cur_seed = 32'd1;
		cur_level = 3'd7;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_word = '0;
		cfg_valid = 1'b0;
		cfg_word = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_before_generate();
		test_small_grids();
		test_full_grid();
		test_level_change();
		test_output_stall();
		test_random();
		settle_idle();
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("diamond_square_heightmap_core verification clean");
		else
			$display("diamond_square_heightmap_core verification failed");
		$finish;
	end
endmodule
